FILE: src/tcw_pkg.sv
// Shared types and constants for the text console writer.
package tcw_pkg;

  // Field widths of the channels and the configuration port.
  localparam int OP_W   = 1;
  localparam int CHAR_W = 8;
  localparam int ATTR_W = 8;
  localparam int POS_W  = 11;
  localparam int CELL_W = 16;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_PUT   = 1'b0;
  localparam logic [OP_W-1:0] OP_CLEAR = 1'b1;

  // Character codes with special handling.
  localparam logic [CHAR_W-1:0] CH_BS       = 8'h08;
  localparam logic [CHAR_W-1:0] CH_TAB      = 8'h09;
  localparam logic [CHAR_W-1:0] CH_LF       = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_CR       = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_PRINT_LO = 8'h20;
  localparam logic [CHAR_W-1:0] CH_PRINT_HI = 8'h7F;

  // Blank cell (white on black space) and the attribute after reset.
  localparam logic [CELL_W-1:0] BLANK_CELL = 16'h0F20;
  localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h0F;

  // Controller states.
  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_EXEC,
    ST_COPY,
    ST_DRAIN,
    ST_BLANK
  } tcw_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_item;
    logic exec;
    logic copy_rd;
    logic blank_wr;
    logic walk_zero;
    logic walk_bottom;
    logic walk_inc;
  } tcw_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_clear;
    logic will_scroll;
    logic copy_last;
    logic blank_last;
  } tcw_sts_t;

endpackage

FILE: src/tcw_in_if.sv
// Input channel carrying one character or clear command per beat.
interface tcw_in_if;
  import tcw_pkg::*;

  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   op;
  logic [CHAR_W-1:0] char_code;

  modport source (output valid, op, char_code, input ready);
  modport sink   (input valid, op, char_code, output ready);
endinterface

FILE: src/tcw_out_if.sv
// Result channel carrying the cursor and cell write report per beat.
interface tcw_out_if;
  import tcw_pkg::*;

  logic              valid;
  logic              ready;
  logic [POS_W-1:0]  cursor_position;
  logic              cell_written;
  logic [POS_W-1:0]  cell_address;
  logic [CELL_W-1:0] cell_value;
  logic              scrolled;

  modport source (output valid, cursor_position, cell_written, cell_address, cell_value,
                  scrolled, input ready);
  modport sink   (input valid, cursor_position, cell_written, cell_address, cell_value,
                  scrolled, output ready);
endinterface

FILE: src/tcw_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // One write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

FILE: src/tcw_ctrl.sv
// Controller state machine: item sequencing, screen walks and result valid.
module tcw_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  tcw_pkg::tcw_sts_t sts,
  output tcw_pkg::tcw_cmd_t cmd
);
  import tcw_pkg::*;

  tcw_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       slot_free;

  // The result register can take a new beat when empty or draining now.
  assign slot_free = !out_valid_r || out_ready;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_INIT: begin
        if (sts.blank_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (slot_free) begin
          if (sts.is_clear) begin
            state_nxt = ST_BLANK;
          end else if (sts.will_scroll) begin
            state_nxt = ST_COPY;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_COPY: begin
        if (sts.copy_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_BLANK;
      end
      ST_BLANK: begin
        if (sts.blank_last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_INIT;
      end
    endcase
  end

  // Outputs and datapath commands.
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      ST_INIT, ST_BLANK: begin
        cmd.blank_wr = 1'b1;
        cmd.walk_inc = 1'b1;
      end
      ST_IDLE: begin
        in_ready      = 1'b1;
        cmd.load_item = in_valid;
      end
      ST_EXEC: begin
        cmd.exec      = slot_free;
        cmd.walk_zero = slot_free;
      end
      ST_COPY: begin
        cmd.copy_rd  = 1'b1;
        cmd.walk_inc = 1'b1;
      end
      ST_DRAIN: begin
        cmd.walk_bottom = 1'b1;
      end
      default: begin
        cmd = '0;
      end
    endcase
    out_valid_nxt = cmd.exec ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  assign out_valid = out_valid_r;

  // State and result valid registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

FILE: src/tcw_dpath.sv
// Datapath: cursor, attribute, cell memory walks and the result register.
module tcw_dpath #(
  parameter int COLUMNS  = 80,
  parameter int ROWS     = 25,
  parameter int TAB_STOP = 8
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  tcw_pkg::tcw_cmd_t           cmd,
  output tcw_pkg::tcw_sts_t           sts,
  input  logic [tcw_pkg::OP_W-1:0]    in_op,
  input  logic [tcw_pkg::CHAR_W-1:0]  in_char,
  input  logic                        cfg_we,
  input  logic [tcw_pkg::ATTR_W-1:0]  cfg_wdata,
  output logic [tcw_pkg::POS_W-1:0]   out_cursor_position,
  output logic                        out_cell_written,
  output logic [tcw_pkg::POS_W-1:0]   out_cell_address,
  output logic [tcw_pkg::CELL_W-1:0]  out_cell_value,
  output logic                        out_scrolled
);
  import tcw_pkg::*;

  localparam int CELLS  = COLUMNS * ROWS;
  localparam int ADDR_W = $clog2(CELLS);
  localparam int COL_W  = $clog2(COLUMNS + TAB_STOP);
  localparam int ROW_W  = $clog2(ROWS + 1);
  localparam int PH_W   = $clog2(TAB_STOP);

  // Item, cursor and attribute registers.
  logic [OP_W-1:0]   op_r;
  logic [CHAR_W-1:0] ch_r;
  logic [ATTR_W-1:0] attr_r;
  logic [COL_W-1:0]  col_r, col_nxt;
  logic [ROW_W-1:0]  row_r, row_nxt;
  logic [PH_W-1:0]   phase_r, phase_nxt;

  // Walk counter and the pending copy write.
  logic [ADDR_W-1:0] walk_r;
  logic              pend_r;
  logic [ADDR_W-1:0] pend_addr_r;

  // Result payload registers.
  logic [POS_W-1:0]  res_pos_r, res_addr_r;
  logic              res_written_r, res_scrolled_r;
  logic [CELL_W-1:0] res_value_r;

  // Execution terms.
  logic [COL_W-1:0]  col_a;
  logic [PH_W-1:0]   ph_a;
  logic              row_inc;
  logic              written;
  logic              scroll;
  logic [ROW_W-1:0]  row_a;
  logic [ADDR_W-1:0] addr_old, pos_new;
  logic [31:0]       addr_ext, pos_ext;
  logic [CELL_W-1:0] value;

  // RAM ports.
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr, rd_addr;
  logic [CELL_W-1:0] wr_data, rd_data;

  // Character decode: column move, tab phase and line feed.
  always_comb begin
    col_a   = col_r;
    ph_a    = phase_r;
    row_inc = 1'b0;
    written = 1'b0;
    case (ch_r)
      CH_BS: begin
        if (col_r != '0) begin
          col_a = col_r - COL_W'(1);
          ph_a  = (phase_r == '0) ? PH_W'(TAB_STOP - 1) : phase_r - PH_W'(1);
        end
      end
      CH_TAB: begin
        col_a = col_r + COL_W'(TAB_STOP) - COL_W'(phase_r);
        ph_a  = '0;
      end
      CH_CR: begin
        col_a = '0;
        ph_a  = '0;
      end
      CH_LF: begin
        col_a   = '0;
        ph_a    = '0;
        row_inc = 1'b1;
      end
      default: begin
        if (ch_r >= CH_PRINT_LO && ch_r <= CH_PRINT_HI) begin
          written = 1'b1;
          col_a   = col_r + COL_W'(1);
          ph_a    = (phase_r == PH_W'(TAB_STOP - 1)) ? '0 : phase_r + PH_W'(1);
        end
      end
    endcase
  end

  // Column wrap, row overflow and clear.
  always_comb begin
    col_nxt   = col_a;
    phase_nxt = ph_a;
    row_a     = row_r;
    scroll    = 1'b0;
    if (col_a >= COL_W'(COLUMNS)) begin
      col_nxt   = '0;
      phase_nxt = '0;
      row_a     = row_r + ROW_W'(1);
    end else if (row_inc) begin
      row_a = row_r + ROW_W'(1);
    end
    row_nxt = row_a;
    if (row_a >= ROW_W'(ROWS)) begin
      row_nxt = ROW_W'(ROWS - 1);
      scroll  = 1'b1;
    end
    if (op_r == OP_CLEAR) begin
      col_nxt   = '0;
      phase_nxt = '0;
      row_nxt   = '0;
      scroll    = 1'b0;
    end
  end

  // Linear addresses of the written cell and the new cursor.
  assign addr_old = ADDR_W'(row_r) * ADDR_W'(COLUMNS) + ADDR_W'(col_r);
  assign pos_new  = ADDR_W'(row_nxt) * ADDR_W'(COLUMNS) + ADDR_W'(col_nxt);
  assign addr_ext = 32'(addr_old);
  assign pos_ext  = 32'(pos_new);
  assign value    = {attr_r, ch_r};

  // Cell memory write select: copy beat, blank sweep or character store.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = walk_r;
    wr_data = BLANK_CELL;
    if (pend_r) begin
      wr_en   = 1'b1;
      wr_addr = pend_addr_r;
      wr_data = rd_data;
    end else if (cmd.blank_wr) begin
      wr_en = 1'b1;
    end else if (cmd.exec && op_r == OP_PUT && written) begin
      wr_en   = 1'b1;
      wr_addr = addr_old;
      wr_data = value;
    end
  end

  assign rd_addr = walk_r + ADDR_W'(COLUMNS);

  tcw_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELLS)
  ) u_cells (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Status to the controller.
  always_comb begin
    sts.is_clear    = (op_r == OP_CLEAR);
    sts.will_scroll = scroll;
    sts.copy_last   = (walk_r == ADDR_W'(CELLS - COLUMNS - 1));
    sts.blank_last  = (walk_r == ADDR_W'(CELLS - 1));
  end

  // Control registers: cursor, attribute, walk and pending copy.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r   <= '0;
      row_r   <= '0;
      phase_r <= '0;
      attr_r  <= ATTR_RESET;
      walk_r  <= '0;
      pend_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        attr_r <= cfg_wdata;
      end
      if (cmd.exec) begin
        col_r   <= col_nxt;
        row_r   <= row_nxt;
        phase_r <= phase_nxt;
      end
      if (cmd.walk_zero) begin
        walk_r <= '0;
      end else if (cmd.walk_bottom) begin
        walk_r <= ADDR_W'(CELLS - COLUMNS);
      end else if (cmd.walk_inc) begin
        walk_r <= walk_r + ADDR_W'(1);
      end
      pend_r <= cmd.copy_rd;
    end
  end

  // Payload registers: item, copy address and result.
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      op_r <= in_op;
      ch_r <= in_char;
    end
    pend_addr_r <= walk_r;
    if (cmd.exec) begin
      res_pos_r      <= pos_ext[POS_W-1:0];
      res_written_r  <= (op_r == OP_PUT) && written;
      res_addr_r     <= ((op_r == OP_PUT) && written) ? addr_ext[POS_W-1:0] : '0;
      res_value_r    <= ((op_r == OP_PUT) && written) ? value : '0;
      res_scrolled_r <= scroll;
    end
  end

  assign out_cursor_position = res_pos_r;
  assign out_cell_written    = res_written_r;
  assign out_cell_address    = res_addr_r;
  assign out_cell_value      = res_value_r;
  assign out_scrolled        = res_scrolled_r;

endmodule

FILE: src/text_console_writer.sv
// Top level of the text console writer: controller, datapath and checks.
//
//   Channel   Dir  Handshake        Beat contents
//   in_chan   in   valid / ready    op, char_code
//   out_chan  out  valid / ready    cursor_position, cell_written, cell_address,
//                                   cell_value, scrolled
//   cfg       in   cfg_we           cfg_wdata (text attribute)
//
// An ordinary item is accepted in the idle state; the execute state loads the
// result register and is held while that register is stalled. A scroll adds a
// copy walk, a drain state and a blank walk of the bottom row, a clear a blank
// walk of every cell, all through the single write port of the cell memory.
// After reset a blanking pass over every cell runs before the first item is
// accepted. The input is not ready while an item or a walk is active.
module text_console_writer #(
  parameter int COLUMNS  = 80,
  parameter int ROWS     = 25,
  parameter int TAB_STOP = 8
) (
  input  logic                       clk,
  input  logic                       rst_n,
  tcw_in_if.sink                     in_chan,
  tcw_out_if.source                  out_chan,
  input  logic                       cfg_we,
  input  logic [tcw_pkg::ATTR_W-1:0] cfg_wdata
);
  import tcw_pkg::*;

  tcw_cmd_t cmd;
  tcw_sts_t sts;

  // Sequencing.
  tcw_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Cursor, memory and result payload.
  tcw_dpath #(
    .COLUMNS  (COLUMNS),
    .ROWS     (ROWS),
    .TAB_STOP (TAB_STOP)
  ) u_dpath (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .sts                 (sts),
    .in_op               (in_chan.op),
    .in_char             (in_chan.char_code),
    .cfg_we              (cfg_we),
    .cfg_wdata           (cfg_wdata),
    .out_cursor_position (out_chan.cursor_position),
    .out_cell_written    (out_chan.cell_written),
    .out_cell_address    (out_chan.cell_address),
    .out_cell_value      (out_chan.cell_value),
    .out_scrolled        (out_chan.scrolled)
  );

  // Only one item is in work at a time.
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_chan.valid && in_chan.ready |=> !in_chan.ready)
    else $error("input accepted while an item is in work");

  // A result is loaded only into a free result register.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec |-> (!out_chan.valid || out_chan.ready))
    else $error("result register overwritten");

  // Every execution presents a result beat.
  a_exec_result: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec |=> out_chan.valid)
    else $error("execution without a result beat");

  // Memory activities never overlap.
  a_one_access: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.exec, cmd.copy_rd, cmd.blank_wr}))
    else $error("overlapping cell memory commands");

endmodule

FILE: dv/tb_text_console_writer.sv
// Self-checking testbench for the text console writer: directed script, then random text.
module tb_text_console_writer;
  import tcw_pkg::*;

  // Geometry of the console as built by default.
  localparam int COLUMNS  = 80;
  localparam int ROWS     = 25;
  localparam int TAB_STOP = 8;
  localparam int CELLS    = COLUMNS * ROWS;

  // A scroll or clear walks every cell once, so the longest quiet stretch is a
  // cell walk plus a receiver hold-off; the limit is several times that.
  localparam int QUIET_LIMIT    = 10 * CELLS;
  localparam int SETTLE_CYCLES  = 2 * CELLS + 64;
  localparam int PHASES         = 5;
  localparam int ITEMS_PER_PHASE = 330;
  localparam int PRESSURE_HOLD  = 400;

  // One result beat of the console.
  typedef struct packed {
    logic [POS_W-1:0]  cursor_position;
    logic              cell_written;
    logic [POS_W-1:0]  cell_address;
    logic [CELL_W-1:0] cell_value;
    logic              scrolled;
  } console_report_t;

  // One row of the directed script; a pinned row carries its typed-in report.
  typedef struct {
    logic              op;
    logic [CHAR_W-1:0] ch;
    int                reps;
    bit                pinned;
    console_report_t   want;
  } keystroke_row_t;

  localparam console_report_t NOT_PINNED = '0;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [ATTR_W-1:0] cfg_wdata;

  tcw_in_if  in_chan ();
  tcw_out_if out_chan ();

  text_console_writer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .out_chan  (out_chan),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // Shadow of the console: cell memory, cursor and attribute register.
  logic [CELL_W-1:0] shadow_cells [CELLS];
  bit   [6:0]        shadow_col;
  bit   [4:0]        shadow_row;
  logic [ATTR_W-1:0] shadow_attr;

  console_report_t pending_reports[$];
  int              mismatches = 0;

  // Handshake between the sender and the monitor for typed-in expectations.
  bit              item_pinned = 1'b0;
  console_report_t item_pin = '0;

  // Idle control shared by both sides; the hold request is taken by the receiver.
  bit stalls_on  = 1'b1;
  int hold_cycles = 0;

  // Directed script: every control code, the extremes of the character byte,
  // wrap by a printable, wrap by a tab, scroll by line feed and by the last cell.
  keystroke_row_t script [25] = '{
    '{OP_PUT,   8'h41,  1, 1'b1, '{11'd1,    1'b1, 11'd0,    16'h0F41, 1'b0}},
    '{OP_PUT,   CH_BS,  1, 1'b1, '{11'd0,    1'b0, 11'd0,    16'h0000, 1'b0}},
    '{OP_PUT,   CH_BS,  1, 1'b1, '{11'd0,    1'b0, 11'd0,    16'h0000, 1'b0}},
    '{OP_PUT,   CH_TAB, 1, 1'b1, '{11'd8,    1'b0, 11'd0,    16'h0000, 1'b0}},
    '{OP_PUT,   CH_CR,  1, 1'b1, '{11'd0,    1'b0, 11'd0,    16'h0000, 1'b0}},
    '{OP_PUT,   CH_LF,  1, 1'b1, '{11'd80,   1'b0, 11'd0,    16'h0000, 1'b0}},
    '{OP_PUT,   8'h7F,  1, 1'b1, '{11'd81,   1'b1, 11'd80,   16'h0F7F, 1'b0}},
    '{OP_PUT,   8'h20,  1, 1'b1, '{11'd82,   1'b1, 11'd81,   16'h0F20, 1'b0}},
    '{OP_PUT,   8'h1F,  1, 1'b1, '{11'd82,   1'b0, 11'd0,    16'h0000, 1'b0}},
    '{OP_PUT,   8'h80,  1, 1'b1, '{11'd82,   1'b0, 11'd0,    16'h0000, 1'b0}},
    '{OP_PUT,   8'hFF,  1, 1'b1, '{11'd82,   1'b0, 11'd0,    16'h0000, 1'b0}},
    '{OP_PUT,   8'h00,  1, 1'b1, '{11'd82,   1'b0, 11'd0,    16'h0000, 1'b0}},
    '{OP_PUT,   8'h0B,  1, 1'b1, '{11'd82,   1'b0, 11'd0,    16'h0000, 1'b0}},
    '{OP_CLEAR, 8'hFF,  1, 1'b1, '{11'd0,    1'b0, 11'd0,    16'h0000, 1'b0}},
    '{OP_PUT,   CH_TAB, 9, 1'b0, NOT_PINNED},
    '{OP_PUT,   CH_TAB, 1, 1'b1, '{11'd80,   1'b0, 11'd0,    16'h0000, 1'b0}},
    '{OP_PUT,   8'h78, 79, 1'b0, NOT_PINNED},
    '{OP_PUT,   8'h7E,  1, 1'b0, NOT_PINNED},
    '{OP_PUT,   CH_LF, 22, 1'b0, NOT_PINNED},
    '{OP_PUT,   CH_LF,  1, 1'b1, '{11'd1920, 1'b0, 11'd0,    16'h0000, 1'b1}},
    '{OP_PUT,   8'h7A, 79, 1'b0, NOT_PINNED},
    '{OP_PUT,   8'h7F,  1, 1'b1, '{11'd1920, 1'b1, 11'd1999, 16'h0F7F, 1'b1}},
    '{OP_PUT,   CH_TAB, 10, 1'b0, NOT_PINNED},
    '{OP_CLEAR, 8'h00,  1, 1'b1, '{11'd0,    1'b0, 11'd0,    16'h0000, 1'b0}},
    '{OP_PUT,   CH_BS,  1, 1'b1, '{11'd0,    1'b0, 11'd0,    16'h0000, 1'b0}}
  };

  // Apply one keystroke to the shadow console and return the report it causes.
  function automatic console_report_t apply_keystroke(input logic op,
                                                      input logic [CHAR_W-1:0] ch);
    console_report_t rep;
    int unsigned     lin;
    int              i;
    rep = '0;
    if (op == OP_CLEAR) begin
      for (i = 0; i < CELLS; i++) shadow_cells[i] = BLANK_CELL;
      shadow_col = '0;
      shadow_row = '0;
    end else begin
      case (ch)
        CH_BS: begin
          if (shadow_col != '0) shadow_col = shadow_col - 7'd1;
        end
        CH_TAB: begin
          shadow_col = 7'(shadow_col - (shadow_col % TAB_STOP) + TAB_STOP);
        end
        CH_CR: begin
          shadow_col = '0;
        end
        CH_LF: begin
          shadow_col = '0;
          shadow_row = shadow_row + 5'd1;
        end
        default: begin
          if (ch >= CH_PRINT_LO && ch <= CH_PRINT_HI) begin
            lin = shadow_row * COLUMNS + shadow_col;
            rep.cell_written = 1'b1;
            rep.cell_address = lin[POS_W-1:0];
            rep.cell_value   = {shadow_attr, ch};
            shadow_cells[lin] = rep.cell_value;
            shadow_col = shadow_col + 7'd1;
          end
        end
      endcase
      // Column overflow starts a new line.
      if (shadow_col >= COLUMNS) begin
        shadow_col = '0;
        shadow_row = shadow_row + 5'd1;
      end
      // Row overflow scrolls up and blanks the bottom row with the fixed blank.
      if (shadow_row >= ROWS) begin
        for (i = 0; i < CELLS - COLUMNS; i++) shadow_cells[i] = shadow_cells[i + COLUMNS];
        for (i = CELLS - COLUMNS; i < CELLS; i++) shadow_cells[i] = BLANK_CELL;
        shadow_row   = 5'(ROWS - 1);
        rep.scrolled = 1'b1;
      end
    end
    lin = shadow_row * COLUMNS + shadow_col;
    rep.cursor_position = lin[POS_W-1:0];
    return rep;
  endfunction

  function automatic void check_field(input string field, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
      mismatches++;
    end
  endfunction

  // Clock.
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Monitor: check result beats against the oldest expectation, then predict
  // the report of any input beat accepted at this edge.
  always @(posedge clk) begin
    console_report_t got;
    console_report_t want;
    int              i;
    if (!rst_n) begin
      for (i = 0; i < CELLS; i++) shadow_cells[i] = BLANK_CELL;
      shadow_col  = '0;
      shadow_row  = '0;
      shadow_attr = ATTR_RESET;
    end else begin
      if (out_chan.valid && out_chan.ready) begin
        got.cursor_position = out_chan.cursor_position;
        got.cell_written    = out_chan.cell_written;
        got.cell_address    = out_chan.cell_address;
        got.cell_value      = out_chan.cell_value;
        got.scrolled        = out_chan.scrolled;
        if (pending_reports.size() == 0) begin
          $error("report beat with nothing expected: cursor_position 0x%0h",
                 got.cursor_position);
          mismatches++;
        end else begin
          want = pending_reports.pop_front();
          check_field("cursor_position", 32'(want.cursor_position),
                      32'(got.cursor_position));
          check_field("cell_written",    32'(want.cell_written),    32'(got.cell_written));
          check_field("cell_address",    32'(want.cell_address),    32'(got.cell_address));
          check_field("cell_value",      32'(want.cell_value),      32'(got.cell_value));
          check_field("scrolled",        32'(want.scrolled),        32'(got.scrolled));
        end
      end
      if (in_chan.valid && in_chan.ready) begin
        want = apply_keystroke(in_chan.op, in_chan.char_code);
        if (item_pinned) want = item_pin;
        pending_reports.push_back(want);
      end
      if (cfg_we) shadow_attr = cfg_wdata;
    end
  end

  // Watchdog: ends the run when no beat moves on either channel for too long.
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready)) quiet = 0;
      else quiet++;
    end
    $display("end of test: mismatches");
    $finish;
  end

  // Receiver: random stall bursts, plus a long hold-off when one is requested.
  initial begin
    out_chan.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles != 0) begin
        out_chan.ready = 1'b0;
        repeat (hold_cycles) @(negedge clk);
        hold_cycles = 0;
      end
      if (stalls_on && $urandom_range(0, 9) == 0) begin
        out_chan.ready = 1'b0;
        repeat ($urandom_range(1, 16)) @(negedge clk);
      end
      out_chan.ready = 1'b1;
    end
  end

  // Offer one keystroke, with an occasional gap first, and wait until it is taken.
  task automatic send_keystroke(input logic op, input logic [CHAR_W-1:0] ch,
                                input bit pinned, input console_report_t pin);
    @(negedge clk);
    if (stalls_on && $urandom_range(0, 9) == 0) begin
      in_chan.valid = 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk);
    end
    in_chan.valid     = 1'b1;
    in_chan.op        = op;
    in_chan.char_code = ch;
    item_pinned       = pinned;
    item_pin          = pin;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
  endtask

  // Stop offering and wait until every expected report has arrived and the
  // console has finished any screen walk.
  task automatic drain_reports();
    @(negedge clk);
    in_chan.valid = 1'b0;
    while (pending_reports.size() != 0 || !in_chan.ready) @(posedge clk);
  endtask

  // Stimulus: reset, directed script, then random text under several attributes.
  initial begin
    logic [ATTR_W-1:0] attrs [PHASES];
    logic              kop;
    logic [CHAR_W-1:0] kch;
    int                roll;
    int                sent;
    in_chan.valid     = 1'b0;
    in_chan.op        = OP_PUT;
    in_chan.char_code = '0;
    cfg_we            = 1'b0;
    cfg_wdata         = '0;
    rst_n             = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (script[r]) begin
      repeat (script[r].reps)
        send_keystroke(script[r].op, script[r].ch, script[r].pinned, script[r].want);
    end
    drain_reports();

    attrs[0] = 8'h00;
    attrs[1] = 8'hFF;
    attrs[2] = 8'($urandom_range(1, 254));
    attrs[3] = 8'($urandom_range(0, 255));
    attrs[4] = ATTR_RESET;
    for (int p = 0; p < PHASES; p++) begin
      // Attribute write while the console is idle.
      @(negedge clk);
      cfg_we    = 1'b1;
      cfg_wdata = attrs[p];
      @(negedge clk);
      cfg_we    = 1'b0;

      stalls_on = (p != PHASES - 1);
      // Let the result side back up so the input stalls behind it.
      if (p == 1) hold_cycles = PRESSURE_HOLD;

      // Mostly text with line control, some noise bytes and rare clears.
      sent = 0;
      while (sent < ITEMS_PER_PHASE) begin
        roll = $urandom_range(0, 999);
        kop  = OP_PUT;
        if (roll < 3) begin
          kop = OP_CLEAR;
          kch = 8'($urandom_range(0, 255));
        end else if (roll < 60) kch = CH_LF;
        else if (roll < 100) kch = CH_TAB;
        else if (roll < 140) kch = CH_BS;
        else if (roll < 170) kch = CH_CR;
        else if (roll < 250) kch = 8'($urandom_range(0, 255));
        else kch = 8'($urandom_range(CH_PRINT_LO, CH_PRINT_HI));
        send_keystroke(kop, kch, 1'b0, NOT_PINNED);
        // Bytes the console ignores do not count toward the phase.
        if (!(kop == OP_PUT && !(kch inside {CH_BS, CH_TAB, CH_CR, CH_LF}) &&
              (kch < CH_PRINT_LO || kch > CH_PRINT_HI)))
          sent++;
      end
      drain_reports();
    end

    // Give any stray beat time to show up before the verdict.
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

endmodule

FILE: text_console_writer.f
src/tcw_pkg.sv
src/tcw_in_if.sv
src/tcw_out_if.sv
src/tcw_ram.sv
src/tcw_ctrl.sv
src/tcw_dpath.sv
src/text_console_writer.sv
dv/tb_text_console_writer.sv
